@@ rtl/multichannel_ring_audio_mixer_defines.svh @@
// Assertion macros shared by the ring mixer RTL.
`ifndef MULTICHANNEL_RING_AUDIO_MIXER_DEFINES_SVH
`define MULTICHANNEL_RING_AUDIO_MIXER_DEFINES_SVH
`ifndef SYNTHESIS
// Clocked check, disabled while reset is asserted
`define MRMIX_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("mrmix check failed");
// Implication check: antecedent must be followed by consequent in the same cycle
`define MRMIX_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mrmix implication failed");
`else
`define MRMIX_ASSERT(lbl, clk, rst_n, prop)
`define MRMIX_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/mrmix_pkg.sv @@
// Types, codes and helpers for the ring mixer.
package mrmix_pkg;

    localparam int RING_DEPTH_DEF   = 4096;
    localparam int NUM_CHANNELS_DEF = 8;

    localparam int          Q15_SHIFT  = 15;
    localparam logic [12:0] QUEUED_MAX = 13'd8191;
    localparam logic signed [15:0] SAMPLE_MAX = 16'sd32767;
    localparam logic signed [15:0] SAMPLE_MIN = -16'sd32768;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_DRAIN = 2'd1,
        OP_QUERY = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EVAL,
        S_MIX,
        S_OUT
    } state_t;

    // Clamp a 32-bit accumulator to a 16-bit sample
    function automatic logic signed [15:0] sat16(input logic signed [31:0] acc);
        logic signed [15:0] res;
        if (acc > 32'(SAMPLE_MAX))
            res = SAMPLE_MAX;
        else if (acc < 32'(SAMPLE_MIN))
            res = SAMPLE_MIN;
        else
            res = acc[15:0];
        return res;
    endfunction

endpackage

@@ rtl/mrmix_ram.sv @@
// Generic simple dual-port RAM with registered read.
module mrmix_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/multichannel_ring_audio_mixer.sv @@
// Top level of the multichannel stereo ring mixer.
//
// Usage: one input channel (in_valid/in_ready) carries commands: push one
// stereo frame for a channel, drain one frame from the play cursor, or query
// the frames a channel has queued. Every transaction yields exactly one result
// transaction on the output channel (out_valid/out_ready).
// Both rings live in one RAM of RING_DEPTH x 64 bits (left and right
// accumulators side by side); drains and accepted pushes read, modify, write.
// Order: a result enters the output register at the hand-over step, after the
// evaluate and mix steps. A new item is taken only once the last one is handed
// over, as the RAM read-modify-write (evaluate and read, add and write,
// hand over) runs one item at a time. The input side is ready again while a
// result still waits in the output register; a stalled receiver holds the
// block at the hand-over step until the output register frees.
// Reset: cursors and the drop flag clear at once; the RAM is then swept to
// zero, one entry per cycle, and in_ready stays low until the sweep ends.
`include "multichannel_ring_audio_mixer_defines.svh"

module multichannel_ring_audio_mixer
    import mrmix_pkg::*;
#(
    parameter int RING_DEPTH   = RING_DEPTH_DEF,
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         opcode,
    input  logic [2:0]         channel,
    input  logic               first_frame,
    input  logic [12:0]        run_frames,
    input  logic signed [15:0] left_sample,
    input  logic signed [15:0] right_sample,
    input  logic [15:0]        left_gain,
    input  logic [15:0]        right_gain,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] left_out,
    output logic signed [15:0] right_out,
    output logic [12:0]        queued_frames,
    output logic               status
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [32:0] DEPTH_33 = 33'(RING_DEPTH);
    localparam logic [5:0]  NCH      = 6'(NUM_CHANNELS);

    // Control state
    state_t            state_reg, state_next;
    logic [AW-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [31:0]       cursor_reg [NUM_CHANNELS];
    logic [31:0]       cursor_next [NUM_CHANNELS];
    logic [31:0]       play_reg, play_next;
    logic              dropped_reg, dropped_next;
    logic              out_valid_reg, out_valid_next;

    // Payload registers
    op_t               op_reg, op_next;
    logic [2:0]        ch_reg, ch_next;
    logic              first_reg, first_next;
    logic [12:0]       n_reg, n_next;
    logic signed [15:0] ls_reg, ls_next, rs_reg, rs_next;
    logic [15:0]       lg_reg, lg_next, rg_reg, rg_next;
    logic signed [32:0] prod_l_reg, prod_l_next, prod_r_reg, prod_r_next;
    logic              accept_reg, accept_next;
    logic [AW-1:0]     addr_reg, addr_next;
    logic [12:0]       qd_reg, qd_next;
    logic signed [15:0] res_l_reg, res_l_next, res_r_reg, res_r_next;
    logic [12:0]       res_q_reg, res_q_next;
    logic              res_s_reg, res_s_next;
    logic signed [15:0] lo_reg, lo_next, ro_reg, ro_next;
    logic [12:0]       qo_reg, qo_next;
    logic              so_reg, so_next;

    // Evaluation terms
    logic [CW-1:0]     ch_idx;
    logic              ch_ok;
    logic [31:0]       cur, diff, w, wdiff;
    logic              snap;
    logic [32:0]       room;
    logic              first_drop, later_ok, push_ok;
    logic [31:0]       qdiff;

    // Mix terms
    logic signed [32:0] shl, shr;
    logic [31:0]       ram_l, ram_r, sum_l, sum_r;

    // RAM port
    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [63:0]       ram_wdata, ram_rdata;

    mrmix_ram #(
        .WIDTH(64),
        .DEPTH(RING_DEPTH)
    ) u_ring (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // Cursor and run checks on the registered command
    always_comb
    begin
        ch_idx     = CW'(ch_reg);
        ch_ok      = {3'b000, ch_reg} < NCH;
        cur        = cursor_reg[ch_idx];
        diff       = cur - play_reg;
        snap       = first_reg && diff[31];
        w          = snap ? play_reg : cur;
        wdiff      = snap ? 32'd0 : diff;
        room       = DEPTH_33 - {20'd0, n_reg};
        first_drop = (n_reg == 13'd0) || ({20'd0, n_reg} > DEPTH_33)
                     || ({1'b0, wdiff} > room);
        later_ok   = !dropped_reg && ({1'b0, diff} < DEPTH_33);
        push_ok    = ch_ok && (first_reg ? !first_drop : later_ok);
        qdiff      = cur - play_reg;
    end

    // Scale and accumulate terms
    always_comb
    begin
        shl   = prod_l_reg >>> Q15_SHIFT;
        shr   = prod_r_reg >>> Q15_SHIFT;
        ram_l = ram_rdata[63:32];
        ram_r = ram_rdata[31:0];
        sum_l = ram_l + shl[31:0];
        sum_r = ram_r + shr[31:0];
    end

    // Next state and outputs
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        cursor_next    = cursor_reg;
        play_next      = play_reg;
        dropped_next   = dropped_reg;
        out_valid_next = out_valid_reg;
        op_next        = op_reg;
        ch_next        = ch_reg;
        first_next     = first_reg;
        n_next         = n_reg;
        ls_next        = ls_reg;
        rs_next        = rs_reg;
        lg_next        = lg_reg;
        rg_next        = rg_reg;
        prod_l_next    = prod_l_reg;
        prod_r_next    = prod_r_reg;
        accept_next    = accept_reg;
        addr_next      = addr_reg;
        qd_next        = qd_reg;
        res_l_next     = res_l_reg;
        res_r_next     = res_r_reg;
        res_q_next     = res_q_reg;
        res_s_next     = res_s_reg;
        lo_next        = lo_reg;
        ro_next        = ro_reg;
        qo_next        = qo_reg;
        so_next        = so_reg;
        in_ready       = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = addr_reg;
        ram_wdata      = 64'd0;
        ram_re         = 1'b0;
        ram_raddr      = addr_reg;

        // Output register drains independently
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next    = op_t'(opcode);
                    ch_next    = channel;
                    first_next = first_frame;
                    n_next     = run_frames;
                    ls_next    = left_sample;
                    rs_next    = right_sample;
                    lg_next    = left_gain;
                    rg_next    = right_gain;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                prod_l_next = 33'(ls_reg) * 33'($signed({1'b0, lg_reg}));
                prod_r_next = 33'(rs_reg) * 33'($signed({1'b0, rg_reg}));
                accept_next = 1'b0;
                addr_next   = play_reg[AW-1:0];
                qd_next     = 13'd0;
                case (op_reg)
                    OP_PUSH:
                    begin
                        addr_next   = w[AW-1:0];
                        accept_next = push_ok;
                        if (!ch_ok)
                        begin
                            if (first_reg)
                            begin
                                dropped_next = 1'b1;
                            end
                        end
                        else if (first_reg)
                        begin
                            dropped_next = first_drop;
                        end
                        if (push_ok)
                        begin
                            cursor_next[ch_idx] = w + 32'd1;
                        end
                    end
                    OP_DRAIN:
                    begin
                        play_next = play_reg + 32'd1;
                    end
                    OP_QUERY:
                    begin
                        if (ch_ok && !qdiff[31])
                        begin
                            qd_next = (qdiff > 32'(QUEUED_MAX)) ? QUEUED_MAX : qdiff[12:0];
                        end
                    end
                    default:
                    begin
                    end
                endcase
                ram_re     = 1'b1;
                ram_raddr  = addr_next;
                state_next = S_MIX;
            end
            S_MIX:
            begin
                res_l_next = 16'sd0;
                res_r_next = 16'sd0;
                res_q_next = 13'd0;
                res_s_next = 1'b0;
                case (op_reg)
                    OP_PUSH:
                    begin
                        ram_we     = accept_reg;
                        ram_wdata  = {sum_l, sum_r};
                        res_s_next = !accept_reg;
                    end
                    OP_DRAIN:
                    begin
                        ram_we     = 1'b1;
                        ram_wdata  = 64'd0;
                        res_l_next = sat16($signed(ram_l));
                        res_r_next = sat16($signed(ram_r));
                    end
                    OP_QUERY:
                    begin
                        res_q_next = qd_reg;
                    end
                    default:
                    begin
                    end
                endcase
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    lo_next        = res_l_reg;
                    ro_next        = res_r_reg;
                    qo_next        = res_q_reg;
                    so_next        = res_s_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            play_reg      <= 32'd0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                cursor_reg[i] <= 32'd0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            play_reg      <= play_next;
            dropped_reg   <= dropped_next;
            out_valid_reg <= out_valid_next;
            cursor_reg    <= cursor_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        ch_reg     <= ch_next;
        first_reg  <= first_next;
        n_reg      <= n_next;
        ls_reg     <= ls_next;
        rs_reg     <= rs_next;
        lg_reg     <= lg_next;
        rg_reg     <= rg_next;
        prod_l_reg <= prod_l_next;
        prod_r_reg <= prod_r_next;
        accept_reg <= accept_next;
        addr_reg   <= addr_next;
        qd_reg     <= qd_next;
        res_l_reg  <= res_l_next;
        res_r_reg  <= res_r_next;
        res_q_reg  <= res_q_next;
        res_s_reg  <= res_s_next;
        lo_reg     <= lo_next;
        ro_reg     <= ro_next;
        qo_reg     <= qo_next;
        so_reg     <= so_next;
    end

    assign out_valid     = out_valid_reg;
    assign left_out      = lo_reg;
    assign right_out     = ro_reg;
    assign queued_frames = qo_reg;
    assign status        = so_reg;

    // Checks on the sequencing of the ring accesses
    `MRMIX_ASSERT(a_accept_seq, clk, rst_n,
        (in_valid && in_ready) |=> (state_reg == S_EVAL) ##1 (state_reg == S_MIX))
    `MRMIX_ASSERT_IMP(a_ram_we_state, clk, rst_n, ram_we,
        (state_reg == S_MIX) || (state_reg == S_CLEAR))
    `MRMIX_ASSERT(a_play_only_drain, clk, rst_n,
        !$stable(play_reg) |-> $past(state_reg == S_EVAL && op_reg == OP_DRAIN))
    `MRMIX_ASSERT_IMP(a_status_alone, clk, rst_n, out_valid && status,
        left_out == 16'sd0 && right_out == 16'sd0 && queued_frames == 13'd0)

endmodule
